### src/ews_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ews_pkg
// Shared types and constants of the maximum wave speed block.
// ----------------------------------------------------------------------------
package ews_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned GAMMA_WIDTH = 18;
  localparam int unsigned GG_WIDTH    = 20;
  localparam int unsigned DIV_QBITS   = 48;
  localparam int unsigned SQRT_STEPS  = 32;

  localparam logic [GAMMA_WIDTH-1:0] GAMMA_RESET = 18'd91750;
  localparam logic [GAMMA_WIDTH-1:0] ONE_FIX     = 18'd65536;

  typedef enum logic [1:0] {
    DIV_FLOW,
    DIV_KIN,
    DIV_QUOT
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_FLOW,
    ST_FLOW_W,
    ST_KIN,
    ST_KIN_W,
    ST_PRES,
    ST_CHECK,
    ST_QUOT,
    ST_QUOT_W,
    ST_PLO,
    ST_PHI,
    ST_SQRT,
    ST_SQRT_W,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic     load;
    logic     prep;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_take;
    logic     pres;
    logic     prod_lo;
    logic     prod_hi;
    logic     sqrt_start;
    logic     sqrt_take;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic rho_bad;
    logic e_neg;
    logic div_done;
    logic sqrt_done;
    logic commit_ok;
  } sts_t;

endpackage

### src/ews_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ews_div
// Restoring divider, one quotient bit per cycle, 48 quotient bits.
// ----------------------------------------------------------------------------
module ews_div
  import ews_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [63:0]          dividend_i,
  input  logic [32:0]          divisor_i,
  output logic                 done_o,
  output logic                 ovf_o,
  output logic [DIV_QBITS-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 ovf_q, ovf_d;
  logic [5:0]           cnt_q, cnt_d;
  logic [32:0]          rem_q, rem_d;
  logic [32:0]          dvs_q, dvs_d;
  logic [DIV_QBITS-1:0] dq_q, dq_d;
  logic [33:0]          trial;
  logic                 ge;

  always_comb begin
    trial  = {rem_q, dq_q[DIV_QBITS-1]};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dq_d   = dq_q;
    if (start_i) begin
      dvs_d = divisor_i;
      rem_d = {17'd0, dividend_i[63:48]};
      dq_d  = dividend_i[47:0];
      cnt_d = 6'(DIV_QBITS);
      ovf_d = {17'd0, dividend_i[63:48]} >= divisor_i;
      if (ovf_d) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? 33'(trial - {1'b0, dvs_q}) : trial[32:0];
      dq_d  = {dq_q[DIV_QBITS-2:0], ge};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dq_q  <= dq_d;
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quot_o = dq_q;

endmodule

### src/ews_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ews_sqrt
// Integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module ews_sqrt
  import ews_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] x_q, x_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [35:0] shifted;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    shifted = {rem_q, x_q[63:62]};
    trial   = {2'b00, root_q, 2'b01};
    ge      = shifted >= trial;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    x_d     = x_q;
    rem_d   = rem_q;
    root_d  = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'(SQRT_STEPS - 1);
      x_d    = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      x_d    = {x_q[61:0], 2'b00};
      rem_d  = ge ? 34'(shifted - trial) : shifted[33:0];
      root_d = {root_q[30:0], ge};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### src/ews_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ews_dp
// Datapath: operand registers, multipliers, divider, square root, maxima.
// ----------------------------------------------------------------------------
module ews_dp
  import ews_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [95:0]            in_data_i,
  input  logic                   in_last_i,
  input  logic                   in_first_i,
  input  logic                   cfg_wen_i,
  input  logic [GAMMA_WIDTH-1:0] cfg_wdata_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [63:0]            out_data_o,
  output logic                   out_bad_o
);

  logic [GAMMA_WIDTH-1:0] gamma_q;
  logic [31:0]            rho_q;
  logic [31:0]            mmag_q;
  logic signed [31:0]     e_in_q;
  logic                   last_q, first_q;
  logic [63:0]            m2_q;
  logic [GG_WIDTH-1:0]    gg_q;
  logic [31:0]            flow_q, sound_q;
  logic [DIV_QBITS-1:0]   kin_q, quot_q;
  logic                   kin_ovf_q;
  logic                   eneg_q;
  logic [30:0]            e_q;
  logic [43:0]            p_lo_q, p_hi_q;
  logic [31:0]            cell_sound_q, cell_flow_q, sweep_q;
  logic                   cell_err_q;
  logic                   out_valid_q;
  logic [31:0]            out_speed_q, out_domain_q;
  logic                   out_bad_q;

  logic [31:0]            m_in, mmag_in;
  logic [GAMMA_WIDTH-1:0] gm1;
  logic [35:0]            gprod;
  logic [49:0]            eint;
  logic [63:0]            div_a;
  logic [32:0]            div_b;
  logic                   div_done, div_ovf;
  logic [DIV_QBITS-1:0]   div_q;
  logic [67:0]            c2_full;
  logic [63:0]            c2;
  logic                   sqrt_done;
  logic [31:0]            sqrt_root;
  logic                   rho_bad;
  logic [31:0]            snd_n, flw_n, speed, sweep_base, sweep_n;
  logic [32:0]            sum;
  logic                   err_n;

  assign m_in    = in_data_i[63:32];
  assign mmag_in = m_in[31] ? 32'(~m_in + 32'd1) : m_in;
  assign gm1     = (gamma_q > ONE_FIX) ? 18'(gamma_q - ONE_FIX) : '0;
  assign gprod   = gamma_q * gm1;
  assign eint    = {{18{e_in_q[31]}}, e_in_q} - {2'b0, kin_q};
  assign rho_bad = rho_q[31] || (rho_q == '0);
  assign c2_full = {24'd0, p_lo_q} + {p_hi_q, 24'd0};
  assign c2      = (c2_full[67:64] != '0) ? '1 : c2_full[63:0];

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_FLOW: begin
        div_a = {16'd0, mmag_q, 16'd0};
        div_b = {1'b0, rho_q};
      end
      DIV_KIN: begin
        div_a = m2_q;
        div_b = {rho_q, 1'b0};
      end
      DIV_QUOT: begin
        div_a = {17'd0, e_q, 16'd0};
        div_b = {1'b0, rho_q};
      end
      default: begin
        div_a = '0;
        div_b = '1;
      end
    endcase
  end

  ews_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .ovf_o      (div_ovf),
    .quot_o     (div_q)
  );

  ews_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (c2),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // per-cell maxima and sweep maximum including this point
  always_comb begin
    snd_n      = (sound_q > cell_sound_q) ? sound_q : cell_sound_q;
    flw_n      = (flow_q > cell_flow_q) ? flow_q : cell_flow_q;
    sum        = {1'b0, snd_n} + {1'b0, flw_n};
    speed      = sum[32] ? '1 : sum[31:0];
    sweep_base = first_q ? '0 : sweep_q;
    sweep_n    = (last_q && (speed > sweep_base)) ? speed : sweep_base;
    err_n      = cell_err_q || rho_bad || eneg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q      <= GAMMA_RESET;
      cell_sound_q <= '0;
      cell_flow_q  <= '0;
      sweep_q      <= '0;
      cell_err_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wen_i) begin
        gamma_q <= cfg_wdata_i;
      end
      if (cmd_i.commit && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        sweep_q <= sweep_n;
        if (last_q) begin
          cell_sound_q <= '0;
          cell_flow_q  <= '0;
          cell_err_q   <= 1'b0;
        end else begin
          cell_sound_q <= snd_n;
          cell_flow_q  <= flw_n;
          cell_err_q   <= err_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rho_q   <= in_data_i[31:0];
      mmag_q  <= mmag_in;
      e_in_q  <= in_data_i[95:64];
      last_q  <= in_last_i;
      first_q <= in_first_i;
      flow_q  <= '0;
      sound_q <= '0;
      eneg_q  <= 1'b0;
    end
    if (cmd_i.prep) begin
      m2_q <= mmag_q * mmag_q;
      gg_q <= gprod[35:16];
    end
    if (cmd_i.div_take) begin
      unique case (cmd_i.div_sel)
        DIV_FLOW: flow_q <= (div_q[47:32] != '0) ? '1 : div_q[31:0];
        DIV_KIN: begin
          kin_q     <= div_q;
          kin_ovf_q <= div_ovf;
        end
        DIV_QUOT: quot_q <= div_q;
        default: ;
      endcase
    end
    if (cmd_i.pres) begin
      eneg_q <= kin_ovf_q || eint[49];
      e_q    <= eint[30:0];
    end
    if (cmd_i.prod_lo) begin
      p_lo_q <= gg_q * quot_q[23:0];
    end
    if (cmd_i.prod_hi) begin
      p_hi_q <= gg_q * quot_q[47:24];
    end
    if (cmd_i.sqrt_take) begin
      sound_q <= sqrt_root;
    end
    if (cmd_i.commit && last_q) begin
      out_speed_q  <= speed;
      out_domain_q <= sweep_n;
      out_bad_q    <= err_n;
    end
  end

  assign sts_o.rho_bad   = rho_bad;
  assign sts_o.e_neg     = eneg_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.commit_ok = !last_q || !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_domain_q, out_speed_q};
  assign out_bad_o   = out_bad_q;

  a_units_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_done && sqrt_done))
    else $error("divider and square root finished together");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && last_q && out_valid_q) |-> out_ready_i)
    else $error("result overwritten before it was taken");

  a_sqrt_valid_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sqrt_start |-> (!eneg_q && !rho_bad))
    else $error("square root started on a bad state");

endmodule

### src/ews_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ews_ctrl
// Controller: sequences one point through the datapath.
// ----------------------------------------------------------------------------
module ews_ctrl
  import ews_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) begin
        state_d = ST_PREP;
      end
      ST_PREP:   state_d = sts_i.rho_bad ? ST_FINISH : ST_FLOW;
      ST_FLOW:   state_d = ST_FLOW_W;
      ST_FLOW_W: if (sts_i.div_done) begin
        state_d = ST_KIN;
      end
      ST_KIN:    state_d = ST_KIN_W;
      ST_KIN_W:  if (sts_i.div_done) begin
        state_d = ST_PRES;
      end
      ST_PRES:   state_d = ST_CHECK;
      ST_CHECK:  state_d = sts_i.e_neg ? ST_FINISH : ST_QUOT;
      ST_QUOT:   state_d = ST_QUOT_W;
      ST_QUOT_W: if (sts_i.div_done) begin
        state_d = ST_PLO;
      end
      ST_PLO:    state_d = ST_PHI;
      ST_PHI:    state_d = ST_SQRT;
      ST_SQRT:   state_d = ST_SQRT_W;
      ST_SQRT_W: if (sts_i.sqrt_done) begin
        state_d = ST_FINISH;
      end
      ST_FINISH: if (sts_i.commit_ok) begin
        state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_FLOW;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PREP:   cmd_o.prep = 1'b1;
      ST_FLOW:   cmd_o.div_start = 1'b1;
      ST_FLOW_W: cmd_o.div_take = sts_i.div_done;
      ST_KIN: begin
        cmd_o.div_sel   = DIV_KIN;
        cmd_o.div_start = 1'b1;
      end
      ST_KIN_W: begin
        cmd_o.div_sel  = DIV_KIN;
        cmd_o.div_take = sts_i.div_done;
      end
      ST_PRES:   cmd_o.pres = 1'b1;
      ST_QUOT: begin
        cmd_o.div_sel   = DIV_QUOT;
        cmd_o.div_start = 1'b1;
      end
      ST_QUOT_W: begin
        cmd_o.div_sel  = DIV_QUOT;
        cmd_o.div_take = sts_i.div_done;
      end
      ST_PLO:    cmd_o.prod_lo = 1'b1;
      ST_PHI:    cmd_o.prod_hi = 1'b1;
      ST_SQRT:   cmd_o.sqrt_start = 1'b1;
      ST_SQRT_W: cmd_o.sqrt_take = sts_i.sqrt_done;
      ST_FINISH: cmd_o.commit = sts_i.commit_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/euler_max_wave_speed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_max_wave_speed
// Per-cell and per-sweep maximum wave speed of 1-D ideal-gas states.
// ----------------------------------------------------------------------------
// One point is processed at a time. A point with a good state runs the
// single shared divider three times for 48 steps each (flow speed, kinetic
// energy, internal energy over density), then a 32-step square root, plus
// setup states. A point with non-positive density skips all of these; one
// with negative pressure stops before the third division, and its kinetic
// run ends at once when the kinetic term alone overflows the divider.
// The next point is accepted while the previous cell result waits in the
// output register; the last point of a cell stalls in its final state
// until that earlier result has been taken.
module euler_max_wave_speed
  import ews_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wen_i,
  input  logic [GAMMA_WIDTH-1:0] cfg_wdata_i,   // gamma_ratio
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [95:0]            s_axis_tdata,  // mass_density, momentum_x, total_energy
  input  logic                   s_axis_tlast,  // last_in_cell
  input  logic                   s_axis_tuser,  // first_in_sweep
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [63:0]            m_axis_tdata,  // cell_speed, domain_speed
  output logic                   m_axis_tuser   // bad_state
);

  cmd_t cmd;
  sts_t sts;

  ews_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ews_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_first_i  (s_axis_tuser),
    .cfg_wen_i   (cfg_wen_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_bad_o   (m_axis_tuser)
  );

endmodule

### tb/sv/ews_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ews_checker
// Watches both streams of the wave speed block, predicts each cell result
// from the accepted points and compares it with the emitted result.
// ----------------------------------------------------------------------------
module ews_checker
  import ews_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wen_i,
  input  logic [GAMMA_WIDTH-1:0] cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [95:0]            s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [63:0]            m_axis_tdata,
  input  logic                   m_axis_tuser,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [31:0] cell_speed;
    logic [31:0] domain_speed;
    logic        bad_state;
  } cell_result_t;

  localparam logic [63:0] VMAX = 64'hFFFF_FFFF;

  cell_result_t             expected_cells[$];
  logic [GAMMA_WIDTH-1:0]   gamma_q;
  logic [63:0]              sound_max_q, flow_max_q, sweep_max_q;
  logic                     bad_q;
  int                       fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_cells.size();

  function automatic logic [63:0] clip32(logic [63:0] v);
    return (v > VMAX) ? VMAX : v;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] rem, root, bit_q;
    rem = x;
    root = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > rem) bit_q >>= 2;
    while (bit_q != 0) begin
      if (rem >= root + bit_q) begin
        rem -= root + bit_q;
        root = (root >> 1) + bit_q;
      end else begin
        root >>= 1;
      end
      bit_q >>= 2;
    end
    return root;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fails++;
  endtask

  task automatic absorb_point(logic [95:0] data, logic last, logic first);
    logic signed [31:0] rho_s, m_s, e_s;
    logic [63:0] rho, mmag, kin, flow, sound, gm1, gg, qi, r, q, c2, e, speed, hi, lo;
    logic signed [63:0] eint;
    cell_result_t res;
    rho_s = data[31:0];
    m_s   = data[63:32];
    e_s   = data[95:64];
    flow  = 0;
    sound = 0;
    if (first) sweep_max_q = 0;
    if (rho_s <= 0) begin
      bad_q = 1'b1;
    end else begin
      rho  = {32'd0, rho_s};
      mmag = m_s[31] ? {32'd0, -m_s} : {32'd0, m_s};
      if (m_s == 32'sh8000_0000) mmag = 64'h8000_0000;
      kin  = (mmag * mmag) / (rho * 2);
      eint = 64'(signed'(e_s)) - signed'(kin);
      flow = clip32((mmag << FRAC_BITS) / rho);
      if (eint < 0) begin
        bad_q = 1'b1;
      end else begin
        e   = eint;
        gm1 = (gamma_q > ONE_FIX) ? 64'(gamma_q - ONE_FIX) : 64'd0;
        gg  = (64'(gamma_q) * gm1) >> FRAC_BITS;
        qi  = e / rho;
        r   = e % rho;
        if (qi >= (64'd1 << (64 - FRAC_BITS))) begin
          q = '1;
        end else begin
          hi = qi << FRAC_BITS;
          lo = (r << FRAC_BITS) / rho;
          q  = (hi > ~lo) ? '1 : hi + lo;
        end
        if (gg == 0 || q == 0) c2 = 0;
        else if (q > 64'hFFFF_FFFF_FFFF_FFFF / gg) c2 = '1;
        else c2 = gg * q;
        sound = clip32(root64(c2));
      end
    end
    if (sound > sound_max_q) sound_max_q = sound;
    if (flow > flow_max_q) flow_max_q = flow;
    if (last) begin
      speed = clip32(sound_max_q + flow_max_q);
      if (speed > sweep_max_q) sweep_max_q = speed;
      res.cell_speed   = speed[31:0];
      res.domain_speed = sweep_max_q[31:0];
      res.bad_state    = bad_q;
      expected_cells.push_back(res);
      sound_max_q = 0;
      flow_max_q  = 0;
      bad_q       = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t want;
    if (!rst_ni) begin
      gamma_q     <= GAMMA_RESET;
      sound_max_q = 0;
      flow_max_q  = 0;
      sweep_max_q = 0;
      bad_q       = 1'b0;
      fails       = 0;
      expected_cells.delete();
    end else begin
      if (cfg_wen_i) gamma_q <= cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cells.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 0);
        end else begin
          want = expected_cells.pop_front();
          if (m_axis_tdata[31:0] !== want.cell_speed)
            report_mismatch("cell_speed", m_axis_tdata[31:0], want.cell_speed);
          if (m_axis_tdata[63:32] !== want.domain_speed)
            report_mismatch("domain_speed", m_axis_tdata[63:32], want.domain_speed);
          if (m_axis_tuser !== want.bad_state)
            report_mismatch("bad_state", m_axis_tuser, want.bad_state);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb_point(s_axis_tdata, s_axis_tlast, s_axis_tuser);
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives gas states in bursts through the wave speed block under several
// gamma settings, stalls the result side at random and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import ews_pkg::*;

  localparam int IDLE_LIMIT  = 40000;
  localparam int HOLD_CYCLES = 600;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_wen_i = 1'b0;
  logic [GAMMA_WIDTH-1:0] cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [95:0]            s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [63:0]            m_axis_tdata;
  logic                   m_axis_tuser;
  int                     fail_count, pending;
  int                     idle_cycles = 0;
  int                     hold_left = 0;
  bit                     hold_start = 1'b0;

  always #6 clk_i = ~clk_i;

  euler_max_wave_speed dut (.*);

  ews_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  // receiver stall pattern, with a long counted hold-off when asked
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value(int mode);
    case (mode)
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return $urandom;
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  task automatic send_point(logic [31:0] rho, logic [31:0] mom, logic [31:0] en,
                            logic last, logic first);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {en, mom, rho};
    s_axis_tlast  <= last;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic gap_cycles();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 200) : 0;
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_gamma(logic [GAMMA_WIDTH-1:0] g);
    cfg_wen_i   <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_wen_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_cell(bit first, output int npts);
    logic [31:0] rho, mom, en;
    npts = $urandom_range(1, 4);
    for (int p = 0; p < npts; p++) begin
      if ($urandom_range(0, 9) == 0) begin
        rho = pick_value($urandom_range(0, 4));
        mom = pick_value($urandom_range(0, 5));
        en  = pick_value($urandom_range(0, 5));
      end else begin
        rho = $urandom_range(1, 32'h0040_0000);
        mom = $urandom_range(0, 32'h0080_0000);
        if ($urandom_range(0, 1)) mom = -mom;
        en  = $urandom_range(0, 32'h7FFF_FFFF);
        if ($urandom_range(0, 15) == 0) en = -en;
      end
      send_point(rho, mom, en, p == npts - 1, first && p == 0);
      gap_cycles();
    end
  endtask

  initial begin
    logic [GAMMA_WIDTH-1:0] gammas[4];
    int sent;
    int n;
    gammas = '{18'd65536, 18'd196608, 18'd109227, 18'h3FFFF};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and special cases under reset gamma, then one point with gamma zero
    send_point(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b1);
    send_point(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_point(32'h0001_0000, 32'h0004_0000, 32'h0000_0000, 1'b1, 1'b0);
    send_point(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_point(32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_point(32'h0002_0000, 32'hFFFF_0000, 32'h0010_0000, 1'b0, 1'b1);
    send_point(32'h0001_0000, 32'h0000_8000, 32'h0008_0000, 1'b1, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    drain();
    write_gamma(18'd0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0010_0000, 1'b1, 1'b1);
    drain();

    // long receiver hold-off while points keep coming
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    for (int c = 0; c < 6; c++) begin
      send_point(32'h0000_0000, 32'h0, 32'h0, 1'b1, 1'b0);
    end
    drain();

    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_gamma(gammas[ph]);
      while (sent < (ph + 1) * 300) begin
        random_cell($urandom_range(0, 7) == 0, n);
        sent += n;
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
